// ===== rtl/core/lkv_pkg.sv =====
`default_nettype none

package lkv_pkg;

    localparam int LKV_ENTRIES = 16;
    localparam int DATA_W      = 32;
    localparam int CAP_W       = 5;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // register index within the configuration space
    localparam logic CAP_IDX = 1'b0;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_SET = 1'b1;

    localparam logic [DATA_W-1:0] MISS_VALUE = '1;

    // update command broadcast to every entry
    typedef struct packed {
        logic en;
        logic age_all;
        logic wr_data;
    } upd_t;

endpackage

`default_nettype wire

// ===== rtl/core/lru_key_value_cache_core.sv =====
`default_nettype none

// Fully associative key/value cache with least-recently-used replacement.
// Every request (kind 0 get, kind 1 set) gives exactly one result. The block
// takes one request per clock: a request is captured in an input register,
// compared against all entries in parallel in the next cycle, and its result
// is registered at the same edge that updates the entry ages, so the
// following request already sees the updated store. The key compare and
// age update run in parallel across all ENTRIES slots. While a result
// waits for out_ready the input register holds its request and in_ready
// stays low. The store starts empty after reset with no clearing pass.
// The capacity register (byte address 0) limits the entries in use; 0
// acts as 1 and values above ENTRIES act as ENTRIES. Lowering it never
// drops entries, new keys then replace the least recently used one.
module lru_key_value_cache_core
    import lkv_pkg::*;
#(
    parameter int ENTRIES = LKV_ENTRIES
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              kind,
    input  wire logic [DATA_W-1:0] key,
    input  wire logic [DATA_W-1:0] value,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   found,
    output logic      [DATA_W-1:0] read_value,
    output logic                   evicted,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int UW = $clog2(ENTRIES + 1);
    localparam int CW = (UW > CAP_W) ? UW : CAP_W;

    logic [CAP_W-1:0] capacity;

    logic              in_vld_reg;
    logic              kind_reg;
    logic [DATA_W-1:0] key_reg;
    logic [DATA_W-1:0] value_reg;

    logic              out_vld_reg;
    logic              found_reg;
    logic [DATA_W-1:0] read_value_reg;
    logic              evicted_reg;

    logic [UW-1:0] used_reg;
    logic [UW-1:0] used_next;

    logic proc;
    logic hit;
    logic room;
    logic insert;
    logic evict;

    logic [CW-1:0] cap_eff;
    logic [UW-1:0] used_m1;
    logic [AW-1:0] oldest_age;
    logic [AW-1:0] free_idx;
    logic [AW-1:0] hit_age;
    logic [AW-1:0] thr;
    logic [DATA_W-1:0] hit_value;

    logic [ENTRIES-1:0] valid_vec;
    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES-1:0] victim_vec;
    logic [ENTRIES-1:0] sel_vec;
    logic [AW-1:0]      age_arr [ENTRIES];
    logic [DATA_W-1:0]  value_arr [ENTRIES];

    upd_t upd;

    lkv_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    // handshake
    assign proc     = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || proc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            kind_reg  <= kind;
            key_reg   <= key;
            value_reg <= value;
        end
    end

    // effective capacity
    always_comb
    begin
        cap_eff = CW'(capacity);
        if (capacity == '0)
        begin
            cap_eff = CW'(1);
        end
        else if (CW'(capacity) > CW'(ENTRIES))
        begin
            cap_eff = CW'(ENTRIES);
        end
    end

    assign room       = CW'(used_reg) < cap_eff;
    assign used_m1    = used_reg - UW'(1);
    assign oldest_age = used_m1[AW-1:0];
    assign free_idx   = used_reg[AW-1:0];

    assign hit    = |match_vec;
    assign insert = (kind_reg == KIND_SET) && !hit && room;
    assign evict  = (kind_reg == KIND_SET) && !hit && !room;

    always_comb
    begin
        hit_age   = '0;
        hit_value = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (match_vec[i])
            begin
                hit_age   = hit_age | age_arr[i];
                hit_value = hit_value | value_arr[i];
            end
        end
    end

    assign thr = hit ? hit_age : oldest_age;

    assign upd.en      = proc && (hit || (kind_reg == KIND_SET));
    assign upd.age_all = insert;
    assign upd.wr_data = kind_reg == KIND_SET;

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_entry
        assign victim_vec[g] = valid_vec[g] && (age_arr[g] == oldest_age);
        assign sel_vec[g]    = hit    ? match_vec[g] :
                               insert ? (free_idx == AW'(g)) :
                                        victim_vec[g];

        lkv_entry #(
            .AW (AW)
        ) u_entry (
            .clk      (clk),
            .rst_n    (rst_n),
            .upd      (upd),
            .sel      (sel_vec[g]),
            .thr      (thr),
            .wr_key   (key_reg),
            .wr_value (value_reg),
            .key      (key_reg),
            .valid    (valid_vec[g]),
            .match    (match_vec[g]),
            .age      (age_arr[g]),
            .value    (value_arr[g])
        );
    end

    always_comb
    begin
        used_next = used_reg;
        if (proc && insert)
        begin
            used_next = used_reg + UW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
            if (proc)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            found_reg   <= hit;
            evicted_reg <= evict;
            if (kind_reg == KIND_SET)
            begin
                read_value_reg <= '0;
            end
            else if (hit)
            begin
                read_value_reg <= hit_value;
            end
            else
            begin
                read_value_reg <= MISS_VALUE;
            end
        end
    end

    assign out_valid  = out_vld_reg;
    assign found      = found_reg;
    assign read_value = read_value_reg;
    assign evicted    = evicted_reg;

`ifndef ASSERT_OFF
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(used_reg) <= CW'(ENTRIES))
        else $error("entry count above capacity");

    a_used_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(used_reg))
        else $error("valid bits disagree with entry count");

    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
        else $error("key present in more than one entry");

    a_single_victim: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && evict) |-> $onehot(victim_vec))
        else $error("no unique eviction victim");

    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        proc |=> (out_valid && !(evicted && found)))
        else $error("eviction reported together with a hit");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/lkv_cfg.sv =====
`default_nettype none

module lkv_cfg
    import lkv_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output logic      [CAP_W-1:0]  capacity
);

    logic [CAP_W-1:0] capacity_reg;
    logic [CAP_W-1:0] capacity_next;
    logic             reg_idx;

    assign reg_idx = paddr[2];
    assign pready  = 1'b1;

    always_comb
    begin
        capacity_next = capacity_reg;
        if (psel && penable && pwrite && (reg_idx == CAP_IDX))
        begin
            capacity_next = pwdata[CAP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == CAP_IDX)
        begin
            prdata = APB_DW'(capacity_reg);
        end
    end

    assign capacity = capacity_reg;

endmodule

`default_nettype wire

// ===== rtl/core/lkv_entry.sv =====
`default_nettype none

module lkv_entry
    import lkv_pkg::*;
#(
    parameter int AW = 4
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire upd_t              upd,
    input  wire logic              sel,
    input  wire logic [AW-1:0]     thr,
    input  wire logic [DATA_W-1:0] wr_key,
    input  wire logic [DATA_W-1:0] wr_value,
    input  wire logic [DATA_W-1:0] key,
    output logic                   valid,
    output logic                   match,
    output logic      [AW-1:0]     age,
    output logic      [DATA_W-1:0] value
);

    logic              valid_reg;
    logic              valid_next;
    logic [AW-1:0]     age_reg;
    logic [AW-1:0]     age_next;
    logic [DATA_W-1:0] key_reg;
    logic [DATA_W-1:0] value_reg;
    logic              load;

    assign load = upd.en && sel && upd.wr_data;

    always_comb
    begin
        valid_next = valid_reg;
        age_next   = age_reg;
        if (upd.en)
        begin
            if (sel)
            begin
                age_next = '0;
                if (upd.wr_data)
                begin
                    valid_next = 1'b1;
                end
            end
            else if (valid_reg && (upd.age_all || (age_reg < thr)))
            begin
                age_next = age_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            age_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            age_reg   <= age_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            key_reg   <= wr_key;
            value_reg <= wr_value;
        end
    end

    assign valid = valid_reg;
    assign match = valid_reg && (key_reg == key);
    assign age   = age_reg;
    assign value = value_reg;

endmodule

`default_nettype wire
